// ===== design/rcpwa_pkg.sv =====
// package: shared types and constants for the rc pulse width capture block
`timescale 1ns / 1ps
`default_nettype none
package rcpwa_pkg;

    localparam int DEF_SAMPLE_DEPTH = 128;
    localparam int TIME_W           = 32;
    localparam int WIDTH_W          = 12;
    localparam int WIN_W            = 13;
    localparam int LIMIT_W          = 23;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 13;
    localparam int KIND_W           = 2;

    localparam int WIN_MIN_MS       = 10;
    localparam int WIN_MAX_MS       = 5000;
    localparam int US_PER_MS        = 1000;

    localparam logic [WIDTH_W-1:0] RST_MIN_WIDTH = WIDTH_W'(500);
    localparam logic [WIDTH_W-1:0] RST_MAX_WIDTH = WIDTH_W'(3000);
    localparam logic [LIMIT_W-1:0] RST_LIMIT_US  = LIMIT_W'(200 * US_PER_MS);

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_RISE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FALL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_WINDOW = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_SCAN,
        S_DIV,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic capture;
        logic edge_op;
        logic scan;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_done;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== design/rcpwa_ctrl.sv =====
// controller: sequences edge handling, sample scan, division and result transfer
`timescale 1ns / 1ps
`default_nettype none
module rcpwa_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [rcpwa_pkg::KIND_W-1:0] i_kind,
    input  wire logic                        i_out_ready,
    input  wire rcpwa_pkg::t_dp_sts          i_sts,
    output      logic                        o_in_ready,
    output      logic                        o_out_valid,
    output      rcpwa_pkg::t_dp_cmd          o_cmd
);
    import rcpwa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_kind == KIND_QUERY) ? S_SCAN : S_EDGE;
                end
            end
            S_EDGE: begin
                n_state = S_PUSH;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.edge_op   = (r_state == S_EDGE);
        o_cmd.scan      = (r_state == S_SCAN);
        o_cmd.div_start = (r_state == S_SCAN) && i_sts.scan_done;
        o_cmd.div_step  = (r_state == S_DIV) && !i_sts.div_done;
        // output register is free when empty or being emptied this cycle
        o_cmd.load_out  = (r_state == S_PUSH) && (!r_out_valid || i_out_ready);
        o_in_ready      = (r_state == S_IDLE);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== design/rcpwa_dp.sv =====
// datapath: config registers, edge timing, sample ring, scan accumulator, divider
`timescale 1ns / 1ps
`default_nettype none
module rcpwa_dp #(
    parameter int SAMPLE_DEPTH = rcpwa_pkg::DEF_SAMPLE_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rcpwa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rcpwa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [rcpwa_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [rcpwa_pkg::TIME_W-1:0]     i_time_us,
    input  wire rcpwa_pkg::t_dp_cmd              i_cmd,
    output      rcpwa_pkg::t_dp_sts              o_sts,
    output      logic                            o_reading_valid,
    output      logic [rcpwa_pkg::WIDTH_W-1:0]    o_pulse_width_us,
    output      logic                            o_average_valid,
    output      logic [rcpwa_pkg::WIDTH_W-1:0]    o_average_us
);
    import rcpwa_pkg::*;

    localparam int IDX_W   = $clog2(SAMPLE_DEPTH);
    localparam int FILL_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int SUM_W   = $clog2(SAMPLE_DEPTH) + WIDTH_W;
    localparam int DCNT_W  = $clog2(SUM_W + 1);
    localparam int MEM_W   = WIDTH_W + TIME_W;

    // configuration
    logic [WIDTH_W-1:0] r_min;
    logic [WIDTH_W-1:0] r_max;
    logic [LIMIT_W-1:0] r_limit;
    logic [WIN_W-1:0]   cfg_win;

    // captured item
    logic [KIND_W-1:0]  r_kind;
    logic [TIME_W-1:0]  r_t;

    // edge state
    logic [TIME_W-1:0]  r_rise;
    logic               r_armed;
    logic               r_edge_ok;
    logic [WIDTH_W-1:0] r_edge_w;
    logic [TIME_W-1:0]  fall_d;
    logic               fall_ok;

    // sample ring
    logic [MEM_W-1:0]   mem [SAMPLE_DEPTH];
    logic [IDX_W-1:0]   r_wr_idx;
    logic [FILL_W-1:0]  r_fill;

    // scan
    logic [FILL_W-1:0]  r_rd_idx;
    logic               r_rd_vld;
    logic [MEM_W-1:0]   r_rd_data;
    logic               issue;
    logic [TIME_W-1:0]  age;
    logic               in_window;
    logic [SUM_W-1:0]   r_sum;
    logic [FILL_W-1:0]  r_cnt;

    // divider
    logic [SUM_W-1:0]   r_quo;
    logic [FILL_W-1:0]  r_rem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [FILL_W:0]    div_shift;
    logic [FILL_W+1:0]  div_trial;

    // window register saturates to its legal range
    always_comb begin
        cfg_win = i_cfg_data[WIN_W-1:0];
        if (cfg_win < WIN_W'(WIN_MIN_MS)) begin
            cfg_win = WIN_W'(WIN_MIN_MS);
        end else if (cfg_win > WIN_W'(WIN_MAX_MS)) begin
            cfg_win = WIN_W'(WIN_MAX_MS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= RST_MIN_WIDTH;
            r_max   <= RST_MAX_WIDTH;
            r_limit <= RST_LIMIT_US;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_WIDTH:  r_min   <= i_cfg_data[WIDTH_W-1:0];
                CFG_MAX_WIDTH:  r_max   <= i_cfg_data[WIDTH_W-1:0];
                CFG_AVG_WINDOW: r_limit <= LIMIT_W'(32'(cfg_win) * 32'(US_PER_MS));
                default: begin
                end
            endcase
        end
    end

    // falling edge width, modulo the time word
    assign fall_d  = r_t - r_rise;
    assign fall_ok = r_armed && (r_kind == KIND_FALL)
                     && (fall_d >= TIME_W'(r_min)) && (fall_d <= TIME_W'(r_max));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_t    <= i_time_us;
        end
        if (i_cmd.edge_op) begin
            r_edge_w <= fall_d[WIDTH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise    <= '0;
            r_armed   <= 1'b0;
            r_edge_ok <= 1'b0;
            r_wr_idx  <= '0;
            r_fill    <= '0;
        end else if (i_cmd.capture) begin
            r_edge_ok <= 1'b0;
        end else if (i_cmd.edge_op) begin
            r_edge_ok <= fall_ok;
            if (r_kind == KIND_RISE) begin
                r_rise  <= r_t;
                r_armed <= 1'b1;
            end else if (r_kind == KIND_FALL) begin
                r_armed <= 1'b0;
                if (fall_ok) begin
                    r_wr_idx <= (r_wr_idx == IDX_W'(SAMPLE_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
                    if (r_fill != FILL_W'(SAMPLE_DEPTH)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
            end
        end
    end

    // sample ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_op && fall_ok) begin
            mem[r_wr_idx] <= {fall_d[WIDTH_W-1:0], r_t};
        end
    end

    assign issue = i_cmd.scan && (r_rd_idx < r_fill);

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    // age is signed: a sample stamped after the query time is left out
    assign age       = r_t - r_rd_data[TIME_W-1:0];
    assign in_window = !age[TIME_W-1] && (age <= TIME_W'(r_limit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_idx <= '0;
            r_sum    <= '0;
            r_cnt    <= '0;
        end else begin
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_rd_vld && in_window) begin
                r_sum <= r_sum + SUM_W'(r_rd_data[MEM_W-1:TIME_W]);
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_sts.scan_done = (r_rd_idx >= r_fill) && !r_rd_vld;

    // restoring divider, one quotient bit per cycle
    assign div_shift = {r_rem, r_quo[SUM_W-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, r_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= DCNT_W'(SUM_W);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!div_trial[FILL_W+1]) begin
                r_rem <= div_trial[FILL_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= div_shift[FILL_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_sts.div_done = (r_dcnt == '0);

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_kind == KIND_QUERY) begin
                o_reading_valid  <= 1'b0;
                o_pulse_width_us <= '0;
                o_average_valid  <= (r_cnt != '0);
                o_average_us     <= (r_cnt != '0) ? r_quo[WIDTH_W-1:0] : '0;
            end else begin
                o_reading_valid  <= r_edge_ok;
                o_pulse_width_us <= r_edge_ok ? r_edge_w : '0;
                o_average_valid  <= 1'b0;
                o_average_us     <= '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/rc_pulse_width_capture_average.sv =====
// top level: rc servo pulse width capture with windowed average
//
// Takes timestamped rising/falling edges and average queries one item at a
// time. An edge item passes through the edge and push states before its
// result is ready. A query walks the filled part of the sample ring through
// the single read port of the ring memory, one entry a cycle, then runs a
// restoring divider at one quotient bit a cycle. No clearing pass is needed
// after reset; a fill count marks the written entries. A finished result
// waits in an output register, so the next item can be transferred in
// meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module rc_pulse_width_capture_average #(
    parameter int SAMPLE_DEPTH = rcpwa_pkg::DEF_SAMPLE_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rcpwa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rcpwa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire logic [rcpwa_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [rcpwa_pkg::TIME_W-1:0]     i_time_us,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output      logic                            o_reading_valid,
    output      logic [rcpwa_pkg::WIDTH_W-1:0]    o_pulse_width_us,
    output      logic                            o_average_valid,
    output      logic [rcpwa_pkg::WIDTH_W-1:0]    o_average_us
);
    import rcpwa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rcpwa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    rcpwa_dp #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_time_us        (i_time_us),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_reading_valid  (o_reading_valid),
        .o_pulse_width_us (o_pulse_width_us),
        .o_average_valid  (o_average_valid),
        .o_average_us     (o_average_us)
    );

    // one item in flight: busy right after an input transfer
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is in progress");

    // a result is either a reading or an average, never both
    a_one_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_reading_valid && o_average_valid))
        else $error("reading and average flagged in the same result");

    // invalid average reports zero
    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_average_valid) |-> (o_average_us == '0))
        else $error("nonzero average without a valid flag");

    // invalid reading reports zero
    a_pulse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reading_valid) |-> (o_pulse_width_us == '0))
        else $error("nonzero pulse width without a valid flag");

endmodule
`default_nettype wire
